[rtl/linear_probe_hash_map_top_defines.svh]
// assertion macros for the hash map
`ifndef LINEAR_PROBE_HASH_MAP_TOP_DEFINES_SVH
`define LINEAR_PROBE_HASH_MAP_TOP_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define LPHM_ASSERT_IMP(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("label failed");
`define LPHM_ASSERT_NXT(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("label failed");
`else
`define LPHM_ASSERT_IMP(label, clk, rst, a, b)
`define LPHM_ASSERT_NXT(label, clk, rst, a, b)
`endif
`endif

[rtl/lphm_pkg.sv]
package lphm_pkg;
   localparam int CAPACITY_DEF = 1024;
   localparam int KEY_BITS_DEF = 64;
   localparam logic [10:0] CHAIN_MAX = 11'd2047;

   typedef enum logic [1:0] {
      CMD_LOOKUP = 2'd0,
      CMD_INSERT = 2'd1,
      CMD_ERASE  = 2'd2,
      CMD_OTHER  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_NOTFOUND = 2'd1,
      ST_FULL     = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CLEAR,
      S_READ,
      S_CHECK,
      S_UNDO_READ,
      S_UNDO_WRITE,
      S_DONE
   } state_type;
endpackage

[rtl/linear_probe_hash_map_top.sv]
// open-addressing hash map, linear probing over CAPACITY slots
// req_ channel: command, key, hash, value_in; rsp_ channel: status,
// value_out, slot, entry_key, occupancy. one result word per request word.
// one operation at a time. each probe step reads the slot memory
// (registered read data) in S_READ, then compares and writes back in
// S_CHECK. an insert into a full table answers ST_FULL with no probe.
// erase revisits the probed slots to lower their chains; an erase miss
// scans all CAPACITY slots. req_ready returns in the cycle after the
// result word is taken. after reset a clearing pass over all CAPACITY
// slots zeroes the busy marks and chains; req_ready stays low meanwhile.
// the result is held in an output register; while the receiver stalls the
// block holds it and takes no new request.
`include "linear_probe_hash_map_top_defines.svh"
module linear_probe_hash_map_top #(
   parameter int CAPACITY = lphm_pkg::CAPACITY_DEF,
   parameter int KEY_BITS = lphm_pkg::KEY_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [1:0]          req_command,
   input  logic [63:0]         req_key,
   input  logic [31:0]         req_hash,
   input  logic signed [31:0]  req_value_in,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [1:0]          rsp_status,
   output logic signed [31:0]  rsp_value_out,
   output logic [9:0]          rsp_slot,
   output logic [63:0]         rsp_entry_key,
   output logic [10:0]         rsp_occupancy
);
   import lphm_pkg::*;
   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int EW = 1 + 11 + 32 + KEY_BITS + 32;

   // entry: busy, chain, hash, key, value
   logic [EW-1:0] mem [CAPACITY];
   logic [EW-1:0] rd_data_ff;
   logic          wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [EW-1:0] wr_data;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data_ff <= mem[rd_addr];
   end

   state_type state_ff, state_in;
   logic [AW-1:0] start_ff, idx_ff, idx_in, stop_ff, stop_in;
   logic [CW-1:0] cnt_ff, cnt_in, busy_ff, busy_in;
   cmd_type       cmd_ff;
   logic [KEY_BITS-1:0] key_ff;
   logic [31:0]   hash_ff, val_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [1:0]    st_ff, st_in;
   logic [31:0]   vout_ff, vout_in;
   logic [9:0]    slot_ff, slot_in;
   logic [63:0]   ekey_ff, ekey_in;

   logic          e_busy;
   logic [10:0]   e_chain;
   logic [31:0]   e_hash, e_val;
   logic [KEY_BITS-1:0] e_key;
   assign {e_busy, e_chain, e_hash, e_key, e_val} = rd_data_ff;
   logic hmatch, kmatch;
   assign hmatch = e_busy && (e_hash == hash_ff);
   assign kmatch = hmatch && (e_key == key_ff);

   logic accept;
   assign req_ready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign accept = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      idx_in = idx_ff;
      stop_in = stop_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      st_in = st_ff; vout_in = vout_ff; slot_in = slot_ff; ekey_in = ekey_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               idx_in = req_hash[AW-1:0];
               cnt_in = '0;
               st_in = ST_NOTFOUND; vout_in = '0; slot_in = '0; ekey_in = '0;
               if (cmd_type'(req_command) == CMD_INSERT && busy_ff >= CW'(CAPACITY)) begin
                  st_in = ST_FULL;
                  state_in = S_DONE;
               end else state_in = S_READ;
            end
         end
         S_CLEAR: begin
            idx_in = idx_ff + 1'b1;
            if (idx_ff == AW'(CAPACITY - 1)) state_in = S_IDLE;
         end
         S_READ: state_in = S_CHECK;
         S_CHECK: begin
            cnt_in = cnt_ff + 1'b1;
            idx_in = idx_ff + 1'b1;
            state_in = S_READ;
            priority case (cmd_ff)
               CMD_INSERT: begin
                  if (!e_busy) begin
                     st_in = ST_OK; slot_in = 10'(idx_ff);
                     busy_in = busy_ff + 1'b1;
                     state_in = S_DONE;
                  end
               end
               CMD_ERASE: begin
                  if (kmatch) begin
                     st_in = ST_OK; slot_in = 10'(idx_ff);
                     ekey_in = 64'(e_key);
                     if (busy_ff != '0) busy_in = busy_ff - 1'b1;
                     stop_in = idx_ff;
                     idx_in = start_ff;
                     state_in = (idx_ff == start_ff) ? S_DONE : S_UNDO_READ;
                  end else if (cnt_ff == CW'(CAPACITY - 1)) state_in = S_DONE;
               end
               default: begin
                  if (kmatch) begin
                     st_in = ST_OK; slot_in = 10'(idx_ff); vout_in = e_val;
                     state_in = S_DONE;
                  end else if ((!hmatch && e_chain == '0) ||
                               cnt_ff == CW'(CAPACITY - 1)) state_in = S_DONE;
               end
            endcase
         end
         S_UNDO_READ: state_in = S_UNDO_WRITE;
         S_UNDO_WRITE: begin
            idx_in = idx_ff + 1'b1;
            state_in = (idx_ff + 1'b1 == stop_ff) ? S_DONE : S_UNDO_READ;
         end
         S_DONE: begin
            if (!rsp_valid_ff) begin
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // memory port control
   always_comb begin
      rd_addr = idx_ff;
      wr_en = 1'b0;
      wr_addr = idx_ff;
      wr_data = rd_data_ff;
      unique case (state_ff)
         S_CLEAR: begin
            wr_en = 1'b1;
            wr_data = '0;
         end
         S_CHECK: begin
            if (cmd_ff == CMD_INSERT) begin
               wr_en = 1'b1;
               if (!e_busy) wr_data = {1'b1, e_chain, hash_ff, key_ff, val_ff};
               else if (e_chain != CHAIN_MAX)
                  wr_data = {e_busy, e_chain + 11'd1, e_hash, e_key, e_val};
            end else if (cmd_ff == CMD_ERASE && kmatch) begin
               wr_en = 1'b1;
               wr_data = {1'b0, e_chain, e_hash, e_key, e_val};
            end
         end
         S_UNDO_WRITE: begin
            wr_en = 1'b1;
            if (e_chain != '0)
               wr_data = {e_busy, e_chain - 11'd1, e_hash, e_key, e_val};
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         idx_ff <= '0;
         busy_ff <= '0;
         rsp_valid_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff <= idx_in;
         busy_ff <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff <= cnt_in;
      end
      stop_ff <= stop_in;
      st_ff <= st_in; vout_ff <= vout_in; slot_ff <= slot_in; ekey_ff <= ekey_in;
      if (accept) begin
         cmd_ff <= cmd_type'(req_command);
         key_ff <= req_key[KEY_BITS-1:0];
         hash_ff <= req_hash;
         val_ff <= req_value_in;
         start_ff <= req_hash[AW-1:0];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = st_ff;
   assign rsp_value_out = vout_ff;
   assign rsp_slot = slot_ff;
   assign rsp_entry_key = ekey_ff;
   assign rsp_occupancy = 11'(busy_ff);

   `LPHM_ASSERT_IMP(a_no_accept_busy, clock, reset, state_ff != S_IDLE, !req_ready)
   `LPHM_ASSERT_IMP(a_occ_range, clock, reset, 1'b1, busy_ff <= CW'(CAPACITY))
   `LPHM_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_slot))
endmodule

[tb/tb_top.sv]
module tb_top;
   import lphm_pkg::*;

   localparam int SLOTS = 1024;
   localparam int IDLE_LIMIT = 20000;

   typedef struct {
      cmd_type     cmd;
      logic [63:0] key;
      logic [31:0] hash;
      logic [31:0] val;
      bit          drain;
   } op_word;

   typedef struct {
      status_type  status;
      logic [31:0] value;
      logic [9:0]  slot;
      logic [63:0] ekey;
      logic [10:0] occ;
   } map_result;

   logic clock, reset;
   logic req_valid, req_ready, rsp_valid, rsp_ready;
   logic [1:0] req_command;
   logic [63:0] req_key;
   logic [31:0] req_hash;
   logic signed [31:0] req_value_in;
   logic [1:0] rsp_status;
   logic signed [31:0] rsp_value_out;
   logic [9:0] rsp_slot;
   logic [63:0] rsp_entry_key;
   logic [10:0] rsp_occupancy;

   linear_probe_hash_map_top DUT (.*);

   // shadow copy of the table
   bit          tbl_busy [SLOTS];
   logic [10:0] tbl_chain [SLOTS];
   logic [31:0] tbl_hash [SLOTS];
   logic [63:0] tbl_key [SLOTS];
   logic [31:0] tbl_val [SLOTS];
   int          tbl_occ;

   op_word    pending_ops[$];
   map_result expected_rsp[$];
   int        errors, checked, n_found, n_missed, n_found_dummy, n_full;
   int        idle_cycles;
   // words driven by the driver and words taken at the dut
   int        sent_cnt, taken_cnt;

   // generator-side list of live entries
   logic [63:0] live_key[$];
   logic [31:0] live_hash[$];

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   function automatic map_result apply_op(op_word w);
      map_result r;
      int start, idx, i, j;
      r = '{ST_NOTFOUND, 0, 0, 0, 0};
      start = w.hash % SLOTS;
      if (w.cmd == CMD_INSERT) begin
         if (tbl_occ >= SLOTS) begin
            r.status = ST_FULL;
         end else begin
            for (i = 0; i < SLOTS; i++) begin
               idx = (start + i) % SLOTS;
               if (!tbl_busy[idx]) begin
                  tbl_busy[idx] = 1;
                  tbl_hash[idx] = w.hash;
                  tbl_key[idx] = w.key;
                  tbl_val[idx] = w.val;
                  tbl_occ++;
                  r.status = ST_OK;
                  r.slot = 10'(idx);
                  break;
               end
               if (tbl_chain[idx] < CHAIN_MAX) tbl_chain[idx]++;
            end
         end
      end else if (w.cmd == CMD_ERASE) begin
         for (i = 0; i < SLOTS; i++) begin
            idx = (start + i) % SLOTS;
            if (tbl_busy[idx] && tbl_hash[idx] == w.hash && tbl_key[idx] == w.key) break;
         end
         if (i < SLOTS) begin
            for (j = 0; j < i; j++)
               if (tbl_chain[(start + j) % SLOTS] > 0) tbl_chain[(start + j) % SLOTS]--;
            tbl_busy[idx] = 0;
            if (tbl_occ > 0) tbl_occ--;
            r.status = ST_OK;
            r.slot = 10'(idx);
            r.ekey = tbl_key[idx];
         end
      end else begin
         // lookup, and the unused command code behaves the same
         for (i = 0; i < SLOTS; i++) begin
            idx = (start + i) % SLOTS;
            if (tbl_busy[idx] && tbl_hash[idx] == w.hash) begin
               if (tbl_key[idx] == w.key) begin
                  r.status = ST_OK;
                  r.slot = 10'(idx);
                  r.value = tbl_val[idx];
                  break;
               end
            end else if (tbl_chain[idx] == 0) begin
               break;
            end
         end
      end
      r.occ = 11'(tbl_occ);
      return r;
   endfunction

   task automatic report(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %h expected %h", what, got, want);
      errors++;
   endtask

   task automatic add_op(cmd_type c, logic [63:0] k, logic [31:0] h, logic [31:0] v,
                         bit drain = 0);
      op_word w;
      w = '{c, k, h, v, drain};
      pending_ops.push_back(w);
      if (c == CMD_INSERT && live_key.size() < SLOTS) begin
         live_key.push_back(k);
         live_hash.push_back(h);
      end
   endtask

   task automatic add_erase_live();
      int n;
      n = $urandom_range(0, live_key.size() - 1);
      add_op(CMD_ERASE, live_key[n], live_hash[n], $urandom);
      live_key.delete(n);
      live_hash.delete(n);
   endtask

   function automatic logic [63:0] rand_key();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [31:0] rand_hash();
      // half of the hashes crowd into a few slots to build long chains
      if ($urandom_range(0, 1)) return {22'($urandom), 10'($urandom_range(0, 31))};
      return $urandom;
   endfunction

   // driver: bursts with random gaps, words change on the falling edge
   int burst_left = 4, gap_left = 0;
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 0;
         req_command <= 0;
         req_key <= 0;
         req_hash <= 0;
         req_value_in <= 0;
      end else if (!req_valid || taken_cnt == sent_cnt) begin
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 0;
         end else if (pending_ops.size() > 0 &&
                      (!pending_ops[0].drain || expected_rsp.size() == 0)) begin
            op_word w;
            w = pending_ops.pop_front();
            sent_cnt++;
            req_valid <= 1;
            req_command <= w.cmd;
            req_key <= w.key;
            req_hash <= w.hash;
            req_value_in <= w.val;
            if (--burst_left <= 0) begin
               burst_left = $urandom_range(1, 20);
               gap_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
            end
         end else begin
            req_valid <= 0;
         end
      end
   end

   // receiver stall pattern: modes switch every so often
   int rsp_mode = 0, mode_left = 40;
   always @(negedge clock) begin
      if (--mode_left <= 0) begin
         rsp_mode = $urandom_range(0, 2);
         mode_left = $urandom_range(20, 80);
      end
      case (rsp_mode)
         0: rsp_ready <= 1;
         1: rsp_ready <= $urandom_range(0, 1);
         default: rsp_ready <= ($urandom_range(0, 7) == 0);
      endcase
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < SLOTS; s++) begin
            tbl_busy[s] = 0;
            tbl_chain[s] = 0;
         end
         tbl_occ = 0;
      end else begin
         idle_cycles++;
         if (req_valid && req_ready) begin
            op_word w;
            w = '{cmd_type'(req_command), req_key, req_hash, req_value_in, 0};
            expected_rsp.push_back(apply_op(w));
            taken_cnt++;
            idle_cycles = 0;
         end
         if (rsp_valid && rsp_ready) begin
            map_result e;
            idle_cycles = 0;
            if (expected_rsp.size() == 0) begin
               report("unexpected word", rsp_status, 0);
            end else begin
               e = expected_rsp.pop_front();
               checked++;
               if (e.status == ST_OK) n_found++;
               else if (e.status == ST_FULL) n_full++;
               else n_missed++;
               if (rsp_status !== e.status) report("status", rsp_status, e.status);
               if (rsp_value_out !== e.value) report("value_out", rsp_value_out, e.value);
               if (rsp_slot !== e.slot) report("slot", rsp_slot, e.slot);
               if (rsp_entry_key !== e.ekey) report("entry_key", rsp_entry_key, e.ekey);
               if (rsp_occupancy !== e.occ) report("occupancy", rsp_occupancy, e.occ);
            end
         end
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout after %0d idle cycles", idle_cycles);
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   initial begin
      logic [31:0] h;
      int r, fill;
      reset = 1;

      // directed part
      h = 32'h0000_0123;
      add_op(CMD_LOOKUP, 64'h0, 32'h0, 0);
      add_op(CMD_INSERT, 64'h0, 32'h0, 32'h7FFF_FFFF);
      add_op(CMD_INSERT, '1, '1, 32'h8000_0000);
      add_op(CMD_INSERT, 64'h1234, 32'h8000_03FF, 32'hFFFF_FFFF);  // wraps around, lands in slot 1
      add_op(CMD_LOOKUP, 64'h1234, 32'h8000_03FF, 0);
      add_op(CMD_LOOKUP, '1, '1, 0);
      add_op(CMD_INSERT, 64'hAAAA, h, 32'd1);
      add_op(CMD_INSERT, 64'h5555, h, 32'd2);                      // same hash, other key
      add_op(CMD_INSERT, 64'h5555, h, 32'd3);                      // duplicate key
      add_op(CMD_INSERT, 64'h7777, h + 1, 32'd4);
      add_op(CMD_LOOKUP, 64'h5555, h, 0);
      add_op(CMD_LOOKUP, 64'h7777, h + 1, 0);
      add_op(CMD_LOOKUP, 64'h9999, h, 0);                          // miss along a chain
      add_op(CMD_OTHER, 64'hAAAA, h, 0);
      add_op(CMD_OTHER, 64'hBEEF, 32'h0000_0FFF, 0);
      add_op(CMD_ERASE, 64'hAAAA, h, 0);
      add_op(CMD_LOOKUP, 64'h5555, h, 0);
      add_op(CMD_ERASE, 64'hDEAD, h, 0);                           // absent key
      add_op(CMD_LOOKUP, 64'hAAAA, h, 0);
      // erase in generator list too for the entries removed above
      for (int n = live_key.size() - 1; n >= 0; n--)
         if (live_key[n] == 64'hAAAA) begin
            live_key.delete(n);
            live_hash.delete(n);
         end

      // random part
      for (int n = 0; n < 400; n++) begin
         r = $urandom_range(0, 99);
         if (n == 200) begin
            add_op(CMD_LOOKUP, rand_key(), rand_hash(), $urandom, 1);
         end else if ((r < 40 && live_key.size() < 150) || live_key.size() == 0) begin
            if ($urandom_range(0, 9) == 0 && live_key.size() > 0) begin
               fill = $urandom_range(0, live_key.size() - 1);
               add_op(CMD_INSERT, live_key[fill], live_hash[fill], $urandom);
            end else begin
               add_op(CMD_INSERT, rand_key(), rand_hash(), $urandom);
            end
         end else if (r < 65) begin
            fill = $urandom_range(0, live_key.size() - 1);
            add_op(CMD_LOOKUP, live_key[fill], live_hash[fill], $urandom);
         end else if (r < 72) begin
            add_op(CMD_LOOKUP, rand_key(), rand_hash(), $urandom);
         end else if (r < 93) begin
            add_erase_live();
         end else if (r < 95) begin
            add_op(CMD_ERASE, rand_key(), rand_hash(), $urandom);
         end else begin
            add_op(CMD_OTHER, rand_key(), rand_hash(), $urandom);
         end
      end

      add_op(CMD_INSERT, rand_key(), $urandom, $urandom);
      for (int n = 0; n < 4; n++) begin
         fill = $urandom_range(0, live_key.size() - 1);
         add_op(CMD_LOOKUP, live_key[fill], live_hash[fill], 0);
      end
      add_op(CMD_LOOKUP, rand_key(), $urandom, 0);
      add_op(CMD_ERASE, rand_key(), $urandom, 0);
      add_erase_live();
      add_op(CMD_INSERT, rand_key(), $urandom, $urandom);
      add_op(CMD_INSERT, rand_key(), $urandom, $urandom);

      repeat (9) @(posedge clock);
      reset <= 0;

      wait (pending_ops.size() == 0 && !req_valid);
      wait (expected_rsp.size() == 0);
      repeat (50) @(posedge clock);
      $display("checked %0d result words: %0d hits or writes, %0d misses, %0d full",
               checked, n_found, n_missed, n_full);
      $display("crowded chains, wrapped probes, duplicates, erases and stalls exercised");
      if (errors == 0 && expected_rsp.size() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end
endmodule
